// ----- hdl/eot_pkg.sv -----
// Shared types, codes and sizes for the elevator order table.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package eot_pkg;

   localparam int NUM_FLOORS = 4;
   localparam int IDX_W      = $clog2(NUM_FLOORS);
   localparam int CMP_W      = ((IDX_W > 2) ? IDX_W : 2) + 1;

   localparam int BIT_UP   = 0;
   localparam int BIT_DOWN = 1;
   localparam int BIT_CAB  = 2;

   typedef enum logic [1:0] {
      CMD_QUERY  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_RSVD   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ORD_UP   = 2'd0,
      ORD_DOWN = 2'd1,
      ORD_CAB  = 2'd2,
      ORD_RSVD = 2'd3
   } ord_type;

   typedef enum logic [1:0] {
      DIR_UP   = 2'd0,
      DIR_DOWN = 2'd1,
      DIR_IDLE = 2'd2,
      DIR_RSVD = 2'd3
   } dir_type;

   typedef logic [2:0]       bits_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] floor;
      logic [1:0] order_type;
      logic [1:0] car_floor;
      logic [1:0] travel_direction;
      logic       car_stopped;
   } item_type;

   typedef struct packed {
      logic stop_here;
      logic requests_above;
      logic requests_below;
      logic pending_up;
      logic pending_down;
      logic pending_cab;
   } result_type;

   typedef struct packed {
      idx_type  rd_idx;
      logic     wr_en;
      idx_type  wr_idx;
      bits_type wr_bits;
   } tbl_req_type;

endpackage

// ----- hdl/eot_table.sv -----
// Per-floor request bit storage: one read port, one write port.
// Depends on eot_pkg; cleared by reset.
`timescale 1ns / 1ps

module eot_table
   import eot_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tbl_req_type tbl_req,
   output bits_type    rd_bits
);

   bits_type tbl_ff [NUM_FLOORS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FLOORS; i++) begin
            tbl_ff[i] <= '0;
         end
      end else if (tbl_req.wr_en) begin
         tbl_ff[tbl_req.wr_idx] <= tbl_req.wr_bits;
      end
   end

   assign rd_bits = tbl_ff[tbl_req.rd_idx];

endmodule

// ----- hdl/eot_seq.sv -----
// Sequencer: updates one floor, then scans the table one floor per cycle
// through a shared compare unit. Depends on eot_pkg and eot_table ports.
`timescale 1ns / 1ps

module eot_seq
   import eot_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  item_type    item,
   input  logic        out_free,
   input  bits_type    rd_bits,
   output tbl_req_type tbl_req,
   output logic        idle,
   output logic        done,
   output result_type  result
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   item_type  item_ff, item_in;
   idx_type   scan_ff, scan_in;
   bits_type  bits_ff, bits_in;
   logic      above_ff, above_in;
   logic      below_ff, below_in;

   logic [CMP_W-1:0] fl_ext;
   logic [CMP_W-1:0] car_ext;
   logic [CMP_W-1:0] scan_ext;
   logic             fl_valid;
   logic             end_floor;
   bits_type         new_bits;
   bits_type         keep;

   assign fl_ext    = CMP_W'(item_ff.floor);
   assign car_ext   = CMP_W'(item_ff.car_floor);
   assign scan_ext  = CMP_W'(scan_ff);
   assign fl_valid  = fl_ext < CMP_W'(NUM_FLOORS);
   assign end_floor = (fl_ext == '0) || (fl_ext == CMP_W'(NUM_FLOORS - 1));

   always_comb begin
      keep     = bits_type'(3'b011);
      new_bits = rd_bits;
      if (end_floor) begin
         keep = '0;
      end else if (item_ff.travel_direction == DIR_UP) begin
         keep = bits_type'(3'b010);
      end else if (item_ff.travel_direction == DIR_DOWN) begin
         keep = bits_type'(3'b001);
      end
      case (item_ff.command)
         CMD_INSERT: begin
            if (!(item_ff.floor == item_ff.car_floor && item_ff.car_stopped)) begin
               case (item_ff.order_type)
                  ORD_UP:   new_bits[BIT_UP]   = 1'b1;
                  ORD_DOWN: new_bits[BIT_DOWN] = 1'b1;
                  ORD_CAB:  new_bits[BIT_CAB]  = 1'b1;
                  default:  new_bits = rd_bits;
               endcase
            end
         end
         CMD_CLEAR: new_bits = rd_bits & keep;
         default:   new_bits = rd_bits;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      scan_in  = scan_ff;
      bits_in  = bits_ff;
      above_in = above_ff;
      below_in = below_ff;
      tbl_req  = '{rd_idx: scan_ff, wr_en: 1'b0,
                   wr_idx: idx_type'(item_ff.floor), wr_bits: new_bits};
      done     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = item;
               above_in = 1'b0;
               below_in = 1'b0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            tbl_req.rd_idx = idx_type'(item_ff.floor);
            tbl_req.wr_en  = fl_valid;
            bits_in        = fl_valid ? new_bits : '0;
            scan_in        = '0;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_bits != '0) begin
               if (scan_ext > car_ext) above_in = 1'b1;
               if (scan_ext < car_ext) below_in = 1'b1;
            end
            scan_in = scan_ff + idx_type'(1);
            if (scan_ff == idx_type'(NUM_FLOORS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      result.requests_above = above_ff;
      result.requests_below = below_ff;
      result.pending_up     = bits_ff[BIT_UP];
      result.pending_down   = bits_ff[BIT_DOWN];
      result.pending_cab    = bits_ff[BIT_CAB];
      if (bits_ff[BIT_CAB]) begin
         result.stop_here = 1'b1;
      end else if (item_ff.travel_direction == DIR_UP) begin
         result.stop_here = bits_ff[BIT_UP] || (bits_ff[BIT_DOWN] && !above_ff);
      end else if (item_ff.travel_direction == DIR_DOWN) begin
         result.stop_here = bits_ff[BIT_DOWN] || (bits_ff[BIT_UP] && !below_ff);
      end else begin
         result.stop_here = 1'b0;
      end
   end

   assign idle = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      scan_ff  <= scan_in;
      bits_ff  <= bits_in;
      above_ff <= above_in;
      below_ff <= below_in;
   end

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      tbl_req.wr_en |-> state_ff == ST_UPDATE)
      else $error("table write outside update step");

   a_scan_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |=> state_ff == ST_SCAN && scan_ff == '0)
      else $error("scan did not start at floor zero");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_ff == idx_type'(NUM_FLOORS - 1)) |=> state_ff == ST_DONE)
      else $error("scan did not finish after last floor");

   a_done_only_when_free: assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == ST_DONE && out_free)
      else $error("result issued without a free output slot");

endmodule

// ----- hdl/elevator_order_table_unit.sv -----
// Elevator order table: request bits per floor with stop and direction queries.
// A transaction passes the update step, the floor scan and the done step, which
// hands the result to the response register once it is free. New requests stall
// until the sequencer is idle; the scan on the one compare unit sets the pace.
// Reset: synchronous, clears every request bit and drops any pending result.
// Depends on eot_pkg, eot_table and eot_seq.
`timescale 1ns / 1ps

module elevator_order_table_unit
   import eot_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [1:0] req_floor,
   input  logic [1:0] req_order_type,
   input  logic [1:0] req_car_floor,
   input  logic [1:0] req_travel_direction,
   input  logic       req_car_stopped,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_stop_here,
   output logic       rsp_requests_above,
   output logic       rsp_requests_below,
   output logic       rsp_pending_up,
   output logic       rsp_pending_down,
   output logic       rsp_pending_cab
);

   item_type    item;
   tbl_req_type tbl_req;
   bits_type    rd_bits;
   result_type  result;
   result_type  rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        idle;
   logic        done;
   logic        start;
   logic        out_free;

   assign item = '{command: req_command, floor: req_floor,
                   order_type: req_order_type, car_floor: req_car_floor,
                   travel_direction: req_travel_direction,
                   car_stopped: req_car_stopped};

   assign req_stall = !idle;
   assign start     = req_valid && idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   eot_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_bits (rd_bits)
   );

   eot_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .item     (item),
      .out_free (out_free),
      .rd_bits  (rd_bits),
      .tbl_req  (tbl_req),
      .idle     (idle),
      .done     (done),
      .result   (result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stop_here      = rsp_ff.stop_here;
   assign rsp_requests_above = rsp_ff.requests_above;
   assign rsp_requests_below = rsp_ff.requests_below;
   assign rsp_pending_up     = rsp_ff.pending_up;
   assign rsp_pending_down   = rsp_ff.pending_down;
   assign rsp_pending_cab    = rsp_ff.pending_cab;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for elevator_order_table_unit: directed rows, then random orders.
// Checks responses against typed rows' fixed values, else an in-bench model of floor bits.
// Depends on eot_pkg and the elevator_order_table_unit RTL.
`timescale 1ns / 1ps

module tb;
   import eot_pkg::*;

   localparam int NUM_DIRECTED  = 24;
   localparam int RANDOM_ORDERS = 1880;
   localparam int TOTAL_ORDERS  = NUM_DIRECTED + RANDOM_ORDERS;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_AFTER    = 300;
   localparam int DRAIN_CYCLES  = 3 * (NUM_FLOORS + 3);
   localparam int CYCLE_LIMIT   = 500000;

   typedef struct packed {
      item_type   order;
      logic       typed;
      result_type want;
   } row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_command;
   logic [1:0] req_floor;
   logic [1:0] req_order_type;
   logic [1:0] req_car_floor;
   logic [1:0] req_travel_direction;
   logic       req_car_stopped;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_stop_here;
   logic       rsp_requests_above;
   logic       rsp_requests_below;
   logic       rsp_pending_up;
   logic       rsp_pending_down;
   logic       rsp_pending_cab;

   bits_type   floor_bits [NUM_FLOORS] = '{default: '0};
   result_type expected_results [$];
   row_type    directed_orders [NUM_DIRECTED];
   int         failures  = 0;
   int         rsp_count = 0;
   int         cycle_count;

   elevator_order_table_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_floor            (req_floor),
      .req_order_type       (req_order_type),
      .req_car_floor        (req_car_floor),
      .req_travel_direction (req_travel_direction),
      .req_car_stopped      (req_car_stopped),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_stop_here        (rsp_stop_here),
      .rsp_requests_above   (rsp_requests_above),
      .rsp_requests_below   (rsp_requests_below),
      .rsp_pending_up       (rsp_pending_up),
      .rsp_pending_down     (rsp_pending_down),
      .rsp_pending_cab      (rsp_pending_cab)
   );

   // Apply one transaction to the request bits and return the response it yields.
   function automatic result_type apply_to_floors(item_type it);
      result_type r;
      bits_type   cur;
      bits_type   keep;
      logic       above;
      logic       below;
      int         f;
      if (it.command == CMD_INSERT && it.order_type != ORD_RSVD &&
          !(it.floor == it.car_floor && it.car_stopped)) begin
         floor_bits[it.floor][it.order_type] = 1'b1;
      end else if (it.command == CMD_CLEAR) begin
         keep = '0;
         keep[BIT_UP]   = 1'b1;
         keep[BIT_DOWN] = 1'b1;
         if (it.floor == 0 || it.floor == NUM_FLOORS - 1) begin
            keep = '0;
         end else if (it.travel_direction == DIR_UP) begin
            keep[BIT_UP] = 1'b0;
         end else if (it.travel_direction == DIR_DOWN) begin
            keep[BIT_DOWN] = 1'b0;
         end
         floor_bits[it.floor] = floor_bits[it.floor] & keep;
      end
      cur   = floor_bits[it.floor];
      above = 1'b0;
      below = 1'b0;
      for (f = 0; f < NUM_FLOORS; f++) begin
         if (f > it.car_floor && floor_bits[f] != '0) above = 1'b1;
         if (f < it.car_floor && floor_bits[f] != '0) below = 1'b1;
      end
      r = '0;
      if (cur[BIT_CAB]) begin
         r.stop_here = 1'b1;
      end else if (it.travel_direction == DIR_UP) begin
         r.stop_here = cur[BIT_UP] || (cur[BIT_DOWN] && !above);
      end else if (it.travel_direction == DIR_DOWN) begin
         r.stop_here = cur[BIT_DOWN] || (cur[BIT_UP] && !below);
      end
      r.requests_above = above;
      r.requests_below = below;
      r.pending_up     = cur[BIT_UP];
      r.pending_down   = cur[BIT_DOWN];
      r.pending_cab    = cur[BIT_CAB];
      return r;
   endfunction

   function automatic row_type row_entry(cmd_type c, idx_type fl, ord_type ot,
                                         idx_type car, dir_type d, logic stp,
                                         logic typed, result_type want);
      row_type m;
      m.order = {c, fl, ot, car, d, stp};
      m.typed = typed;
      m.want  = want;
      return m;
   endfunction

   function automatic item_type random_order();
      item_type it;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) it.command = CMD_INSERT;
      else if (pick < 80) it.command = CMD_CLEAR;
      else if (pick < 95) it.command = CMD_QUERY;
      else it.command = CMD_RSVD;
      it.floor = 2'($urandom_range(0, NUM_FLOORS - 1));
      it.order_type = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 19) == 0) it.order_type = ORD_RSVD;
      if ($urandom_range(0, 2) == 0) it.car_floor = it.floor;
      else it.car_floor = 2'($urandom_range(0, NUM_FLOORS - 1));
      it.travel_direction = 2'($urandom_range(0, 2));
      if ($urandom_range(0, 11) == 0) it.travel_direction = DIR_RSVD;
      it.car_stopped = ($urandom_range(0, 3) == 0);
      return it;
   endfunction

   task automatic check_bit(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         failures++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // stimulus
   initial begin
      item_type   order;
      result_type predicted;
      int         sent;
      int         burst;
      int         gap;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_command          <= CMD_QUERY;
      req_floor            <= '0;
      req_order_type       <= ORD_UP;
      req_car_floor        <= '0;
      req_travel_direction <= DIR_IDLE;
      req_car_stopped      <= 1'b0;

      directed_orders[0]  = row_entry(CMD_QUERY,  2'd0, ORD_UP,   2'd0, DIR_IDLE, 1'b0,
                                      1'b1, 6'b000000);
      directed_orders[1]  = row_entry(CMD_RSVD,   2'd3, ORD_RSVD, 2'd3, DIR_RSVD, 1'b1,
                                      1'b1, 6'b000000);
      directed_orders[2]  = row_entry(CMD_INSERT, 2'd3, ORD_CAB,  2'd0, DIR_UP,   1'b0,
                                      1'b1, 6'b110001);
      directed_orders[3]  = row_entry(CMD_INSERT, 2'd0, ORD_UP,   2'd0, DIR_IDLE, 1'b1,
                                      1'b1, 6'b010000);
      directed_orders[4]  = row_entry(CMD_INSERT, 2'd0, ORD_UP,   2'd1, DIR_UP,   1'b1,
                                      1'b1, 6'b111100);
      directed_orders[5]  = row_entry(CMD_INSERT, 2'd1, ORD_RSVD, 2'd2, DIR_DOWN, 1'b0,
                                      1'b1, 6'b011000);
      directed_orders[6]  = row_entry(CMD_INSERT, 2'd2, ORD_DOWN, 2'd2, DIR_UP,   1'b0,
                                      1'b0, '0);
      directed_orders[7]  = row_entry(CMD_INSERT, 2'd2, ORD_UP,   2'd3, DIR_DOWN, 1'b0,
                                      1'b1, 6'b101110);
      directed_orders[8]  = row_entry(CMD_CLEAR,  2'd2, ORD_CAB,  2'd2, DIR_UP,   1'b1,
                                      1'b0, '0);
      directed_orders[9]  = row_entry(CMD_CLEAR,  2'd2, ORD_UP,   2'd2, DIR_IDLE, 1'b0,
                                      1'b0, '0);
      directed_orders[10] = row_entry(CMD_CLEAR,  2'd2, ORD_DOWN, 2'd2, DIR_RSVD, 1'b0,
                                      1'b0, '0);
      directed_orders[11] = row_entry(CMD_CLEAR,  2'd2, ORD_UP,   2'd2, DIR_DOWN, 1'b0,
                                      1'b0, '0);
      directed_orders[12] = row_entry(CMD_CLEAR,  2'd3, ORD_UP,   2'd3, DIR_UP,   1'b0,
                                      1'b1, 6'b001000);
      directed_orders[13] = row_entry(CMD_CLEAR,  2'd0, ORD_UP,   2'd0, DIR_DOWN, 1'b0,
                                      1'b1, 6'b000000);
      directed_orders[14] = row_entry(CMD_INSERT, 2'd1, ORD_UP,   2'd1, DIR_DOWN, 1'b0,
                                      1'b1, 6'b100100);
      directed_orders[15] = row_entry(CMD_INSERT, 2'd1, ORD_DOWN, 2'd0, DIR_UP,   1'b0,
                                      1'b1, 6'b110110);
      directed_orders[16] = row_entry(CMD_INSERT, 2'd1, ORD_CAB,  2'd1, DIR_IDLE, 1'b1,
                                      1'b1, 6'b000110);
      directed_orders[17] = row_entry(CMD_INSERT, 2'd2, ORD_CAB,  2'd1, DIR_IDLE, 1'b1,
                                      1'b1, 6'b110001);
      directed_orders[18] = row_entry(CMD_CLEAR,  2'd1, ORD_UP,   2'd2, DIR_UP,   1'b0,
                                      1'b0, '0);
      directed_orders[19] = row_entry(CMD_INSERT, 2'd1, ORD_UP,   2'd0, DIR_DOWN, 1'b0,
                                      1'b0, '0);
      directed_orders[20] = row_entry(CMD_QUERY,  2'd3, ORD_UP,   2'd3, DIR_UP,   1'b1,
                                      1'b1, 6'b001000);
      directed_orders[21] = row_entry(CMD_CLEAR,  2'd2, ORD_UP,   2'd2, DIR_IDLE, 1'b0,
                                      1'b1, 6'b001000);
      directed_orders[22] = row_entry(CMD_CLEAR,  2'd1, ORD_UP,   2'd1, DIR_DOWN, 1'b0,
                                      1'b1, 6'b100100);
      directed_orders[23] = row_entry(CMD_CLEAR,  2'd1, ORD_UP,   2'd1, DIR_UP,   1'b0,
                                      1'b1, 6'b000000);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sent = 0;
      while (sent < TOTAL_ORDERS) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < TOTAL_ORDERS) begin
            order = (sent < NUM_DIRECTED) ? directed_orders[sent].order : random_order();
            req_valid            <= 1'b1;
            req_command          <= order.command;
            req_floor            <= order.floor;
            req_order_type       <= order.order_type;
            req_car_floor        <= order.car_floor;
            req_travel_direction <= order.travel_direction;
            req_car_stopped      <= order.car_stopped;
            @(posedge clock);
            while (req_stall) @(posedge clock);
            predicted = apply_to_floors(order);
            if (sent < NUM_DIRECTED && directed_orders[sent].typed)
               expected_results.push_back(directed_orders[sent].want);
            else
               expected_results.push_back(predicted);
            sent++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // response stall pattern, with one long hold once traffic is flowing
   initial begin
      int stretch;
      int stall_pct;
      bit held;
      held = 1'b0;
      forever begin
         stretch = $urandom_range(10, 80);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         if (!held && rsp_count >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         repeat (stretch) begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_stop_here, rsp_requests_above, rsp_requests_below,
                rsp_pending_up, rsp_pending_down, rsp_pending_cab};
         rsp_count++;
         if (expected_results.size() == 0) begin
            $error("response transaction with none outstanding: %b", got);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_bit("stop_here",      want.stop_here,      got.stop_here);
            check_bit("requests_above", want.requests_above, got.requests_above);
            check_bit("requests_below", want.requests_below, got.requests_below);
            check_bit("pending_up",     want.pending_up,     got.pending_up);
            check_bit("pending_down",   want.pending_down,   got.pending_down);
            check_bit("pending_cab",    want.pending_cab,    got.pending_cab);
         end
      end
   end

endmodule
